// ===== rtl/core/round_robin_task_scheduler_defines.svh =====
// assertion macros shared by the scheduler checker
`ifndef ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH

// same-cycle implication, masked during reset
`define RRTS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked during reset
`define RRTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also covers reset itself
`define RRTS_ASSERT_RESET(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/rrts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_pkg
// types and command codes shared by the round-robin task scheduler
// ----------------------------------------------------------------------------
package rrts_pkg;

   localparam int CMD_W   = 2;
   localparam int DATA_W  = 32;
   localparam int INDEX_W = 3;

   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELAY  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SWITCH = 2'd2;
   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [DATA_W-1:0]  delay_ms;
      logic [DATA_W-1:0]  saved_sp;
      logic [INDEX_W-1:0] task_index;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] current_task;
      logic [DATA_W-1:0]  next_sp;
      logic               switch_request;
      logic [DATA_W-1:0]  tick_count;
   } rsp_type;

endpackage

// ===== rtl/core/round_robin_task_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// millisecond tick, task delays and round-robin context switching
// ----------------------------------------------------------------------------
// One item is handled at a time and gives exactly one result. Delay and
// load go straight to the result; a context switch stores the outgoing
// stack pointer and selects in the accepting cycle, addresses the stack ram
// with the new slot in S_SW_RD, then takes its registered read data in
// S_SW_DATA; a tick sweeps the wake times, which sit in a single-port-read
// ram, one real task per cycle. A new item is taken the cycle after the
// result has been moved into the output register, even if that result is
// still waiting for a transfer. Stack pointers read for a slot that was
// never loaded or saved are undefined; no clearing pass runs after reset.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler
   import rrts_pkg::*;
#(
   parameter int NUM_TASKS = 5
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int NUM_REAL = NUM_TASKS - 1;
   localparam int TASK_W   = $clog2(NUM_TASKS);
   localparam int WAKE_AW  = (NUM_REAL > 1) ? $clog2(NUM_REAL) : 1;
   localparam logic [TASK_W-1:0] IDLE_SLOT = TASK_W'(NUM_REAL);

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_TICK    = 3'd1;
   localparam logic [2:0] S_SW_RD   = 3'd2;
   localparam logic [2:0] S_SW_DATA = 3'd3;
   localparam logic [2:0] S_DONE    = 3'd4;

   // control state
   logic [2:0]            state_ff,     state_in;
   logic [TASK_W-1:0]     scan_ff,      scan_in;
   logic                  rd_valid_ff,  rd_valid_in;
   logic [WAKE_AW-1:0]    rd_idx_ff,    rd_idx_in;
   logic [DATA_W-1:0]     counter_ff,   counter_in;
   logic [TASK_W-1:0]     running_ff,   running_in;
   logic [NUM_REAL-1:0]   ready_ff,     ready_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // result payload
   logic [DATA_W-1:0]     res_sp_ff,    res_sp_in;
   logic                  res_req_ff,   res_req_in;
   rsp_type               rsp_data_ff;

   logic                  accept;
   logic                  rsp_load;
   logic                  real_running;
   logic [TASK_W-1:0]     pick;
   logic [DATA_W-1:0]     slot_ext;
   logic                  slot_ok;

   // ram ports
   logic                  wake_we;
   logic [DATA_W-1:0]     wake_wdata;
   logic [DATA_W-1:0]     wake_rdata;
   logic                  stack_we;
   logic [TASK_W-1:0]     stack_waddr;
   logic [DATA_W-1:0]     stack_rdata;

   assign req_ready    = (state_ff == S_IDLE);
   assign accept       = req_valid && req_ready;
   assign real_running = (running_ff != IDLE_SLOT);
   assign slot_ext     = DATA_W'(req_data.task_index);
   assign slot_ok      = (slot_ext < DATA_W'(NUM_TASKS));

   // wake time written by a delay of a real task, counter plus delay mod 2^32
   assign wake_we    = accept && (req_data.command == CMD_DELAY) && real_running;
   assign wake_wdata = counter_ff + req_data.delay_ms;

   // outgoing stack pointer on a switch, initial value on a load
   assign stack_we    = accept && ((req_data.command == CMD_SWITCH) ||
                                   ((req_data.command == CMD_LOAD) && slot_ok));
   assign stack_waddr = (req_data.command == CMD_SWITCH) ? running_ff
                                                         : slot_ext[TASK_W-1:0];

   rrts_ram #(
      .DEPTH (NUM_REAL),
      .WIDTH (DATA_W)
   ) u_wake_ram (
      .clock   (clock),
      .wr_en   (wake_we),
      .wr_addr (running_ff[WAKE_AW-1:0]),
      .wr_data (wake_wdata),
      .rd_addr (scan_ff[WAKE_AW-1:0]),
      .rd_data (wake_rdata)
   );

   // the switch writes in its accept cycle and addresses the read in S_SW_RD,
   // so the read that it uses never overlaps the write of the same entry
   rrts_ram #(
      .DEPTH (NUM_TASKS),
      .WIDTH (DATA_W)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_waddr),
      .wr_data (req_data.saved_sp),
      .rd_addr (running_ff),
      .rd_data (stack_rdata)
   );

   rrts_rr_pick #(
      .NUM_TASKS (NUM_TASKS)
   ) u_pick (
      .ready (ready_ff),
      .from  (running_ff),
      .pick  (pick)
   );

   // sequencer
   always_comb begin
      state_in    = state_ff;
      scan_in     = scan_ff;
      rd_valid_in = rd_valid_ff;
      rd_idx_in   = rd_idx_ff;
      counter_in  = counter_ff;
      running_in  = running_ff;
      ready_in    = ready_ff;
      res_sp_in   = res_sp_ff;
      res_req_in  = res_req_ff;
      rsp_load    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_sp_in  = '0;
               res_req_in = 1'b0;
               unique case (req_data.command)
                  CMD_TICK: begin
                     counter_in  = counter_ff + DATA_W'(1);
                     res_req_in  = 1'b1;
                     scan_in     = '0;
                     rd_valid_in = 1'b0;
                     state_in    = S_TICK;
                  end
                  CMD_DELAY: begin
                     // a delay while idle runs changes nothing
                     if (real_running) begin
                        ready_in[running_ff[WAKE_AW-1:0]] = 1'b0;
                        res_req_in                        = 1'b1;
                     end
                     state_in = S_DONE;
                  end
                  CMD_SWITCH: begin
                     running_in = pick;
                     state_in   = S_SW_RD;
                  end
                  CMD_LOAD: begin
                     state_in = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_TICK: begin
            // wake check on the entry read in the previous cycle
            if (rd_valid_ff && !ready_ff[rd_idx_ff] && (counter_ff >= wake_rdata)) begin
               ready_in[rd_idx_ff] = 1'b1;
            end
            if (scan_ff < TASK_W'(NUM_REAL)) begin
               rd_valid_in = 1'b1;
               rd_idx_in   = scan_ff[WAKE_AW-1:0];
               scan_in     = scan_ff + TASK_W'(1);
            end else begin
               rd_valid_in = 1'b0;
               if (!rd_valid_ff) begin
                  state_in = S_DONE;
               end
            end
         end
         S_SW_RD: begin
            state_in = S_SW_DATA;
         end
         S_SW_DATA: begin
            res_sp_in = stack_rdata;
            state_in  = S_DONE;
         end
         S_DONE: begin
            // hand over once the output register is free or being emptied
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rd_idx_ff    <= '0;
         counter_ff   <= '0;
         running_ff   <= '0;
         ready_ff     <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         rd_valid_ff  <= rd_valid_in;
         rd_idx_ff    <= rd_idx_in;
         counter_ff   <= counter_in;
         running_ff   <= running_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      res_sp_ff  <= res_sp_in;
      res_req_ff <= res_req_in;
      if (rsp_load) begin
         rsp_data_ff.current_task   <= INDEX_W'(running_ff);
         rsp_data_ff.next_sp        <= res_sp_ff;
         rsp_data_ff.switch_request <= res_req_ff;
         rsp_data_ff.tick_count     <= counter_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/rrts_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rrts_ram #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 32
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/core/rrts_rr_pick.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_rr_pick
// round-robin selection of the next ready real task, idle slot as fallback
// ----------------------------------------------------------------------------
module rrts_rr_pick #(
   parameter int NUM_TASKS = 5
) (
   input  logic [NUM_TASKS-2:0]             ready,
   input  logic [$clog2(NUM_TASKS)-1:0]     from,
   output logic [$clog2(NUM_TASKS)-1:0]     pick
);

   localparam int NUM_REAL = NUM_TASKS - 1;
   localparam int TASK_W   = $clog2(NUM_TASKS);
   localparam int FLAG_AW  = (NUM_REAL > 1) ? $clog2(NUM_REAL) : 1;

   logic [TASK_W-1:0] base;

   // idle slot folds onto slot zero, so its search starts at slot one
   assign base = (from >= TASK_W'(NUM_REAL)) ? (from - TASK_W'(NUM_REAL)) : from;

   // highest offset first, so the nearest ready slot wins
   always_comb begin
      logic [TASK_W:0]   sum;
      logic [TASK_W-1:0] cand;
      pick = TASK_W'(NUM_REAL);
      for (int i = NUM_REAL; i >= 1; i--) begin
         sum  = {1'b0, base} + (TASK_W + 1)'(i);
         cand = (sum >= (TASK_W + 1)'(NUM_REAL)) ?
                TASK_W'(sum - (TASK_W + 1)'(NUM_REAL)) : TASK_W'(sum);
         if (ready[cand[FLAG_AW-1:0]]) begin
            pick = cand;
         end
      end
   end

endmodule

// ===== rtl/core/rrts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_checker
// port-level checks for the round-robin task scheduler
// ----------------------------------------------------------------------------
`include "round_robin_task_scheduler_defines.svh"

module rrts_checker
   import rrts_pkg::*;
#(
   parameter int NUM_TASKS = 5
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // nothing is offered straight out of reset
   `RRTS_ASSERT_RESET(a_rsp_idle_after_reset, reset, !rsp_valid, "result offered after reset")

   // a stalled result holds
   `RRTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

   // a switch request never comes with a stack pointer
   `RRTS_ASSERT_NOW(a_req_no_sp, rsp_valid && rsp_data.switch_request, rsp_data.next_sp == '0, "switch request with non-zero stack pointer")

   // running task is always a valid slot
   `RRTS_ASSERT_NOW(a_task_range, rsp_valid, 32'(rsp_data.current_task) < NUM_TASKS || NUM_TASKS > 8, "running task out of range")

   // no item is taken in the cycle after a transfer in
   `RRTS_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "second item taken while one is in work")

endmodule

bind round_robin_task_scheduler rrts_checker #(.NUM_TASKS(NUM_TASKS)) u_rrts_checker (.*);
